@@ design/best_fit_allocator_top_macros.svh @@
// Assertion macros for the best-fit allocator.
`ifndef BEST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_NEVER(lbl, expr, msg)
`endif
`endif

@@ design/bfa_pkg.sv @@
// Shared constants, types and codes of the best-fit allocator.
package bfa_pkg;

  localparam int SLOTS        = 64;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int PAGE_SHIFT   = 12;
  localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
  localparam int HEADER_BYTES = 16;
  localparam int PAGE_PAYLOAD = PAGE_BYTES - HEADER_BYTES;
  localparam int ADDR_W       = 32;
  localparam int SIZE_W       = 12;
  localparam int REQ_W        = 16;
  localparam int STAMP_W      = 16;
  localparam int PAGES_W      = 17;
  localparam int CFG_INDEX_W  = 2;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_MEMORY = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POOL_BASE  = 2'd0,
    REG_PAGE_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] order;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    slot_t            entry;
  } table_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } table_clr_t;

  typedef struct packed {
    logic              best_found;
    logic [IDX_W-1:0]  best_idx;
    logic [ADDR_W-1:0] best_addr;
    logic [SIZE_W-1:0] best_size;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } scan_res_t;

endpackage

@@ design/best_fit_allocator_top.sv @@
// Best-fit allocator top level: control sequencer, pool state and result register.
// Each request of 1 to 4080 bytes reads every entry of the 64-entry free-slot
// table through the table's single read port, one entry per cycle; the request
// then passes through the decide and commit states, and the next request is
// taken right after the commit. Zero-size and oversize requests skip the scan
// and go straight to the commit. The result sits in an output register, so a
// request may be accepted while the previous result still waits; the commit
// waits only when that register is still full.
// Configuration writes are taken every cycle and take effect at once; write
// them only while no request is in flight. No clearing pass follows reset.
`include "best_fit_allocator_top_macros.svh"

module best_fit_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bfa_pkg::REQ_W-1:0]       request_size,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [bfa_pkg::ADDR_W-1:0]      payload_address,
  output logic [bfa_pkg::SIZE_W-1:0]      granted_size,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfa_pkg::ADDR_W-1:0]      cfg_data
);

  bfa_pkg::state_t              state, state_next;
  logic [bfa_pkg::ADDR_W-1:0]   pool_base;
  logic [bfa_pkg::PAGES_W-1:0]  page_limit;
  logic [bfa_pkg::PAGES_W-1:0]  pages_used;
  logic [bfa_pkg::STAMP_W-1:0]  stamp;
  logic [bfa_pkg::CNT_W-1:0]    rd_cnt;
  logic [bfa_pkg::SIZE_W-1:0]   req_sz;
  logic                         refused;
  bfa_pkg::status_t             res_status;
  logic [bfa_pkg::ADDR_W-1:0]   res_addr;
  logic [bfa_pkg::SIZE_W-1:0]   res_ssize;
  logic                         take_best;
  logic                         tail_ok;
  logic [bfa_pkg::IDX_W-1:0]    tail_idx;

  logic                         accept;
  logic                         out_free;
  logic                         issue;
  logic                         start;
  logic                         scan_done;
  logic                         split;
  logic [bfa_pkg::SIZE_W-1:0]   rem;
  logic [bfa_pkg::ADDR_W-1:0]   page_addr;

  bfa_pkg::slot_t               rd_entry;
  logic                         rd_valid;
  bfa_pkg::table_wr_t           tbl_wr;
  bfa_pkg::table_clr_t          tbl_clr;
  bfa_pkg::scan_res_t           scan_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == bfa_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign issue     = (state == bfa_pkg::S_SCAN) && (rd_cnt != bfa_pkg::CNT_W'(bfa_pkg::SLOTS));
  assign scan_done = (state == bfa_pkg::S_SCAN) && (rd_cnt == bfa_pkg::CNT_W'(bfa_pkg::SLOTS));
  assign start     = accept;
  assign page_addr = pool_base + (bfa_pkg::ADDR_W'(pages_used) << bfa_pkg::PAGE_SHIFT);
  assign rem       = res_ssize - req_sz;
  assign split     = !refused && tail_ok && (rem > bfa_pkg::SIZE_W'(bfa_pkg::HEADER_BYTES));

  bfa_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_cnt[bfa_pkg::IDX_W-1:0]),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr       (tbl_wr),
    .clr      (tbl_clr)
  );

  bfa_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .issue     (issue),
    .issue_idx (rd_cnt[bfa_pkg::IDX_W-1:0]),
    .rd_entry  (rd_entry),
    .rd_valid  (rd_valid),
    .req_sz    (req_sz),
    .stamp     (stamp),
    .res       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    tbl_wr.en     = 1'b0;
    tbl_wr.idx    = tail_idx;
    tbl_wr.entry  = '{addr:  res_addr + bfa_pkg::ADDR_W'(bfa_pkg::HEADER_BYTES)
                             + bfa_pkg::ADDR_W'(req_sz),
                      size:  rem - bfa_pkg::SIZE_W'(bfa_pkg::HEADER_BYTES),
                      order: stamp};
    tbl_clr.en    = 1'b0;
    tbl_clr.idx   = tail_idx;
    unique case (state)
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          if ((request_size == '0) ||
              (request_size > bfa_pkg::REQ_W'(bfa_pkg::PAGE_PAYLOAD))) begin
            state_next = bfa_pkg::S_COMMIT;
          end else begin
            state_next = bfa_pkg::S_SCAN;
          end
        end
      end
      bfa_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = bfa_pkg::S_DECIDE;
        end
      end
      bfa_pkg::S_DECIDE: begin
        state_next = bfa_pkg::S_COMMIT;
      end
      bfa_pkg::S_COMMIT: begin
        if (out_free) begin
          tbl_wr.en  = split;
          tbl_clr.en = !refused && take_best;
          state_next = bfa_pkg::S_IDLE;
        end
      end
      default: state_next = bfa_pkg::S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      page_limit <= bfa_pkg::PAGES_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bfa_pkg::REG_POOL_BASE) begin
        pool_base <= cfg_data;
      end else if (cfg_index == bfa_pkg::REG_PAGE_LIMIT) begin
        page_limit <= cfg_data[bfa_pkg::PAGES_W-1:0];
      end
    end
  end

  // Pool and insertion counters, scan counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_used <= '0;
      stamp      <= '0;
      rd_cnt     <= '0;
    end else begin
      if (accept) begin
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + bfa_pkg::CNT_W'(1);
      end
      if ((state == bfa_pkg::S_DECIDE) && !scan_res.best_found &&
          (pages_used < page_limit)) begin
        pages_used <= pages_used + bfa_pkg::PAGES_W'(1);
      end
      if (tbl_wr.en) begin
        stamp <= stamp + bfa_pkg::STAMP_W'(1);
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_sz  <= request_size[bfa_pkg::SIZE_W-1:0];
      if (request_size == '0) begin
        refused    <= 1'b1;
        res_status <= bfa_pkg::ST_ZERO_SIZE;
      end else if (request_size > bfa_pkg::REQ_W'(bfa_pkg::PAGE_PAYLOAD)) begin
        refused    <= 1'b1;
        res_status <= bfa_pkg::ST_TOO_LARGE;
      end else begin
        refused    <= 1'b0;
        res_status <= bfa_pkg::ST_GRANTED;
      end
    end else if (state == bfa_pkg::S_DECIDE) begin
      take_best <= scan_res.best_found;
      if (scan_res.best_found) begin
        res_addr  <= scan_res.best_addr;
        res_ssize <= scan_res.best_size;
        tail_ok   <= 1'b1;
        tail_idx  <= scan_res.best_idx;
      end else if (pages_used >= page_limit) begin
        refused    <= 1'b1;
        res_status <= bfa_pkg::ST_NO_MEMORY;
      end else begin
        res_addr  <= page_addr;
        res_ssize <= bfa_pkg::SIZE_W'(bfa_pkg::PAGE_PAYLOAD);
        tail_ok   <= scan_res.free_found;
        tail_idx  <= scan_res.free_idx;
      end
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == bfa_pkg::S_COMMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == bfa_pkg::S_COMMIT) && out_free) begin
      status <= res_status;
      if (refused) begin
        payload_address <= '0;
        granted_size    <= '0;
      end else begin
        payload_address <= res_addr + bfa_pkg::ADDR_W'(bfa_pkg::HEADER_BYTES);
        granted_size    <= split ? req_sz : res_ssize;
      end
    end
  end

  `BFA_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second word accepted during a request")
  `BFA_ASSERT(a_page_in_limit, (!$past(rst) && (pages_used != $past(pages_used))) |-> ($past(pages_used) < $past(page_limit)), "page carved beyond the pool limit")
  `BFA_ASSERT(a_best_fits, ((state == bfa_pkg::S_COMMIT) && take_best && !refused) |-> (res_ssize >= req_sz), "chosen slot smaller than request")
  `BFA_ASSERT(a_stamp_on_insert, (!$past(rst) && (stamp != $past(stamp))) |-> $past(tbl_wr.en), "insertion stamp moved without a table insert")

endmodule

@@ design/bfa_table.sv @@
// Free-slot table: one synchronous memory plus per-entry valid flops.
module bfa_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bfa_pkg::IDX_W-1:0] rd_idx,
  output bfa_pkg::slot_t            rd_entry,
  output logic                      rd_valid,
  input  bfa_pkg::table_wr_t        wr,
  input  bfa_pkg::table_clr_t       clr
);

  bfa_pkg::slot_t           mem [bfa_pkg::SLOTS];
  logic [bfa_pkg::SLOTS-1:0] valid;
  logic [bfa_pkg::SLOTS-1:0] valid_next;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.entry;
    end
    rd_entry <= mem[rd_idx];
    rd_valid <= valid[rd_idx];
  end

  // A taken slot may be refilled with its own tail: set wins over clear.
  always_comb begin
    valid_next = valid;
    if (clr.en) begin
      valid_next[clr.idx] = 1'b0;
    end
    if (wr.en) begin
      valid_next[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

@@ design/bfa_scan.sv @@
// Best-fit compare unit: walks the table reads and keeps the best candidate.
module bfa_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        issue,
  input  logic [bfa_pkg::IDX_W-1:0]   issue_idx,
  input  bfa_pkg::slot_t              rd_entry,
  input  logic                        rd_valid,
  input  logic [bfa_pkg::SIZE_W-1:0]  req_sz,
  input  logic [bfa_pkg::STAMP_W-1:0] stamp,
  output bfa_pkg::scan_res_t          res
);

  logic                        cmp_valid;
  logic [bfa_pkg::IDX_W-1:0]   cmp_idx;
  logic [bfa_pkg::SIZE_W-1:0]  best_rem;
  logic [bfa_pkg::STAMP_W-1:0] best_age;
  logic                        fits;
  logic                        better;
  logic [bfa_pkg::SIZE_W-1:0]  rem;
  logic [bfa_pkg::STAMP_W-1:0] age;

  // Read data arrives in the cycle after its index is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= issue;
    end
    cmp_idx <= issue_idx;
  end

  always_comb begin
    fits   = cmp_valid && rd_valid && (rd_entry.size >= req_sz);
    rem    = rd_entry.size - req_sz;
    age    = stamp - bfa_pkg::STAMP_W'(1) - rd_entry.order;
    // Strict compares keep the lowest index on a full tie.
    better = fits && (!res.best_found || (rem < best_rem) ||
                      ((rem == best_rem) && (age < best_age)));
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.best_found <= 1'b0;
      res.free_found <= 1'b0;
    end else begin
      if (better) begin
        res.best_found <= 1'b1;
        res.best_idx   <= cmp_idx;
        res.best_addr  <= rd_entry.addr;
        res.best_size  <= rd_entry.size;
        best_rem       <= rem;
        best_age       <= age;
      end
      if (cmp_valid && !rd_valid && !res.free_found) begin
        res.free_found <= 1'b1;
        res.free_idx   <= cmp_idx;
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the best-fit allocator: free-slot predictor, scoreboard and drivers.
module tb_top;
  import bfa_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 600;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } grant_t;

  class allocator_scoreboard;
    logic [ADDR_W-1:0]  pool_base;
    logic [PAGES_W-1:0] page_limit;
    logic [ADDR_W-1:0]  slot_addr[SLOTS];
    logic [SIZE_W-1:0]  slot_bytes[SLOTS];
    logic [STAMP_W-1:0] slot_stamp[SLOTS];
    bit                 slot_used[SLOTS];
    logic [STAMP_W-1:0] stamp;
    logic [PAGES_W-1:0] pages_used;
    grant_t             pending_grants[$];
    int                 errors;
    int                 requests;
    int                 status_seen[4];
    int                 full_table_grants;
    int                 exact_fits;

    function new();
      pool_base  = '0;
      page_limit = PAGES_W'(256);
      foreach (slot_used[i]) begin
        slot_addr[i]  = '0;
        slot_bytes[i] = '0;
        slot_stamp[i] = '0;
        slot_used[i]  = 1'b0;
      end
      stamp      = '0;
      pages_used = '0;
      errors     = 0;
      requests   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      full_table_grants = 0;
      exact_fits        = 0;
    endfunction

    function void apply_register(cfg_reg_t idx, logic [ADDR_W-1:0] value);
      case (idx)
        REG_POOL_BASE:  pool_base  = value;
        REG_PAGE_LIMIT: page_limit = value[PAGES_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // Size of a random free slot, zero when the table is empty.
    function int free_slot_size();
      int sizes[$];
      foreach (slot_used[i])
        if (slot_used[i]) sizes.push_back(slot_bytes[i]);
      if (sizes.size() == 0) return 0;
      return sizes[$urandom_range(sizes.size() - 1)];
    endfunction

    function void note_request(logic [REQ_W-1:0] req);
      grant_t             g;
      int                 best;
      int                 tail;
      logic [SIZE_W-1:0]  best_rem;
      logic [SIZE_W-1:0]  leftover;
      logic [STAMP_W-1:0] best_age;
      logic [STAMP_W-1:0] age;
      logic [ADDR_W-1:0]  base_addr;
      logic [SIZE_W-1:0]  whole;
      g.status  = ST_GRANTED;
      g.address = '0;
      g.size    = '0;
      best      = -1;
      tail      = -1;
      best_rem  = '0;
      best_age  = '0;
      base_addr = '0;
      whole     = '0;
      requests++;
      if (req == 0) begin
        g.status = ST_ZERO_SIZE;
      end else if (req > PAGE_PAYLOAD) begin
        g.status = ST_TOO_LARGE;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_bytes[i] >= req) begin
            leftover = slot_bytes[i] - req[SIZE_W-1:0];
            // smaller age is more recent; ties on age go to the lower index
            age = stamp - 16'd1 - slot_stamp[i];
            if (best < 0 || leftover < best_rem ||
                (leftover == best_rem && age < best_age)) begin
              best     = i;
              best_rem = leftover;
              best_age = age;
            end
          end
        end
        if (best >= 0) begin
          base_addr       = slot_addr[best];
          whole           = slot_bytes[best];
          slot_used[best] = 1'b0;
          tail            = best;
          if (best_rem == 0) exact_fits++;
        end else if (pages_used >= page_limit) begin
          g.status = ST_NO_MEMORY;
        end else begin
          base_addr  = pool_base + (ADDR_W'(pages_used) << PAGE_SHIFT);
          pages_used = pages_used + 1'b1;
          whole      = SIZE_W'(PAGE_PAYLOAD);
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i] && tail < 0) tail = i;
          end
          if (tail < 0) full_table_grants++;
        end
        if (g.status == ST_GRANTED) begin
          leftover = whole - req[SIZE_W-1:0];
          if (leftover > HEADER_BYTES && tail >= 0) begin
            slot_addr[tail]  = base_addr + HEADER_BYTES + req;
            slot_bytes[tail] = leftover - SIZE_W'(HEADER_BYTES);
            slot_stamp[tail] = stamp;
            slot_used[tail]  = 1'b1;
            stamp            = stamp + 1'b1;
            g.size           = req[SIZE_W-1:0];
          end else begin
            g.size = whole;
          end
          g.address = base_addr + HEADER_BYTES;
        end
      end
      status_seen[g.status]++;
      pending_grants.push_back(g);
    endfunction

    function void check_result(logic [1:0] st, logic [ADDR_W-1:0] addr,
                               logic [SIZE_W-1:0] sz);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $error("result word with nothing pending: status %0d address %h size %0d",
               st, addr, sz);
        errors++;
        return;
      end
      g = pending_grants.pop_front();
      if (st !== g.status) begin
        $error("status: expected %0d, got %0d", g.status, st);
        errors++;
      end
      if (addr !== g.address) begin
        $error("payload_address: expected %h, got %h", g.address, addr);
        errors++;
      end
      if (sz !== g.size) begin
        $error("granted_size: expected %0d, got %0d", g.size, sz);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [REQ_W-1:0]       request_size;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [ADDR_W-1:0]      payload_address;
  logic [SIZE_W-1:0]      granted_size;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]      cfg_data;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_go;
  logic hold_done;
  int   hold_left;

  allocator_scoreboard sb = new();

  best_fit_allocator_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .request_size    (request_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .payload_address (payload_address),
    .granted_size    (granted_size),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      // hold off the result side long enough for requests to back up
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(request_size);
      if (out_valid && out_ready) sb.check_result(status, payload_address, granted_size);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(logic [REQ_W-1:0] sz);
    in_valid     <= 1'b1;
    request_size <= sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_request_size();
    int roll;
    int fit;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 8) return REQ_W'($urandom_range(65535, PAGE_PAYLOAD + 1));
    if (roll < 18) begin
      // aim at a free slot: exact fit or a leftover too small to split
      fit = sb.free_slot_size();
      if (fit > HEADER_BYTES) return REQ_W'(fit - $urandom_range(HEADER_BYTES, 0));
      if (fit > 0) return REQ_W'(fit);
    end
    if (roll < 45) return REQ_W'($urandom_range(64, 1));
    if (roll < 70) return REQ_W'($urandom_range(1024, 65));
    return REQ_W'($urandom_range(PAGE_PAYLOAD, 2048));
  endfunction

  task automatic run_random(int count, int tx_pct, int rx_pct, bit pause_midway);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain_results();
      if ($urandom_range(99) < tx_idle_pct) begin
        in_valid     <= 1'b0;
        request_size <= REQ_W'($urandom);
        repeat ($urandom_range(100, 1)) @(posedge clk);
      end
      send_request(pick_request_size());
    end
    drain_results();
  endtask

  initial begin
    logic [REQ_W-1:0] first_pass[] = '{16'd0, 16'd65535, 16'd4081, 16'd4080, 16'd1,
                                       16'd4063, 16'd4000, 16'd48, 16'd4000, 16'd20};
    logic [REQ_W-1:0] second_pass[] = '{16'd100, 16'd200, 16'd4000, 16'd4000, 16'd30,
                                        16'd64, 16'd2, 16'd4080, 16'd17, 16'd33};
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    request_size <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_POOL_BASE;
    cfg_data     <= '0;
    hold_go      <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tiny pool: whole-page grants, exact fit, unsplit slot, then the pool runs dry
    write_reg(REG_POOL_BASE, 32'h1000_0000);
    write_reg(REG_PAGE_LIMIT, 32'd3);
    foreach (first_pass[i]) send_request(first_pass[i]);
    drain_results();

    // top of the address space so page addresses wrap; equal-size slots for recency
    write_reg(REG_PAGE_LIMIT, 32'd65536);
    write_reg(REG_POOL_BASE, 32'hFFFF_F000);
    foreach (second_pass[i]) send_request(second_pass[i]);
    drain_results();

    // fill the slot table with small tails, then random traffic at full rate
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (80) send_request(16'd4000);
    run_random(380, 0, 0, 1'b0);

    write_reg(REG_POOL_BASE, 32'h0000_0000);
    run_random(450, 64, 0, 1'b1);

    hold_go <= 1'b1;
    run_random(400, 0, 64, 1'b0);

    // pool limit below the pages already handed out: only table hits succeed
    write_reg(REG_PAGE_LIMIT, 32'd1);
    run_random(200, 22, 22, 1'b0);

    write_reg(REG_PAGE_LIMIT, 32'd65536);
    write_reg(REG_POOL_BASE, 32'h8000_0000);
    run_random(220, 22, 22, 1'b0);

    $display("tb_top: %0d requests, %0d granted, %0d zero size, %0d oversize, %0d out of memory",
             sb.requests, sb.status_seen[ST_GRANTED], sb.status_seen[ST_ZERO_SIZE],
             sb.status_seen[ST_TOO_LARGE], sb.status_seen[ST_NO_MEMORY]);
    $display("tb_top: %0d exact fits, %0d whole pages granted with the slot table full",
             sb.exact_fits, sb.full_table_grants);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/bfa_pkg.sv
design/bfa_table.sv
design/bfa_scan.sv
design/best_fit_allocator_top.sv
tb/tb_top.sv
